@@ design/wsd_pkg.sv @@
package wsd_pkg;

  // Default for the widest payload length accepted without an error
  localparam int unsigned LENGTH_BITS_DEF = 64;

  // Result queue depth; a beat may push two results
  localparam int unsigned RES_DEPTH = 4;

  // Seven-bit length codes that select an extended length field
  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  // Byte counts of the extended length fields and of the mask key
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  typedef enum logic [2:0] {
    PH_HDR0  = 3'd0,
    PH_HDR1  = 3'd1,
    PH_EXT   = 3'd2,
    PH_KEY   = 3'd3,
    PH_DATA  = 3'd4,
    PH_DRAIN = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
  } wsd_in_t;

  typedef struct packed {
    kind_e       kind;
    logic        fin;
    logic        rsv1;
    logic        rsv2;
    logic        rsv3;
    logic [3:0]  opcode;
    logic        masked;
    logic [62:0] payload_length;
    logic [7:0]  out_byte;
    logic        frame_last;
  } wsd_out_t;

  typedef struct packed {
    logic     valid;
    wsd_out_t res;
  } wsd_slot_t;

  // Results caused by one accepted beat, in delivery order
  typedef struct packed {
    wsd_slot_t res0;
    wsd_slot_t res1;
  } wsd_push_t;

endpackage

@@ design/wsd_stream_if.sv @@
interface wsd_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/wsd_parser.sv @@
module wsd_parser #(
  parameter int unsigned LENGTH_BITS = wsd_pkg::LENGTH_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  wsd_pkg::wsd_in_t  beat_i,
  output wsd_pkg::wsd_push_t push_o
);

  localparam int unsigned LenW = (LENGTH_BITS >= 63) ? 63 : LENGTH_BITS;

  function automatic wsd_pkg::wsd_out_t mk_res(
    input wsd_pkg::kind_e kind,
    input logic [8:0]     hb,
    input logic [LenW-1:0] len,
    input logic [7:0]     byt,
    input logic           last
  );
    wsd_pkg::wsd_out_t r;
    r.kind           = kind;
    r.fin            = hb[7];
    r.rsv1           = hb[6];
    r.rsv2           = hb[5];
    r.rsv3           = hb[4];
    r.opcode         = hb[3:0];
    r.masked         = hb[8];
    r.payload_length = 63'(len);
    r.out_byte       = byt;
    r.frame_last     = last;
    return r;
  endfunction

  function automatic wsd_pkg::wsd_out_t mk_err();
    wsd_pkg::wsd_out_t r;
    r            = '0;
    r.kind       = wsd_pkg::KIND_ERROR;
    r.frame_last = 1'b1;
    return r;
  endfunction

  wsd_pkg::phase_e phase_q, phase_d;
  logic [3:0]      cnt_q, cnt_d, cnt_n;
  logic [LenW-1:0] acc_q, acc_d, acc_n;
  logic            ovf_q, ovf_d, ovf_n;
  logic [LenW-1:0] rem_q, rem_d, rem_n;
  logic [31:0]     key_q, key_d, key_n;
  logic [1:0]      idx_q, idx_d, idx_n;
  logic [8:0]      hb_q, hb_d, hb_n;
  logic            disc_q, disc_d, disc_n;

  logic [7:0]      b;
  logic            endb;
  logic [6:0]      len7;
  logic            len_ext;
  logic [LenW-1:0] acc_shift;
  logic            ovf_shift;
  logic [3:0]      cnt_dec;
  logic            cnt_zero;
  logic [LenW-1:0] rem_dec;
  logic            data_last;
  logic [7:0]      key_byte;
  logic            hdr_at_hdr1, ext_fin, ext_bad, ext_key, key_fin;
  logic            hdr_done, len_zero, go_idle;

  assign b         = beat_i.data_byte;
  assign endb      = beat_i.buffer_end;
  assign len7      = b[6:0];
  assign len_ext   = (len7 == wsd_pkg::LEN7_EXT16) || (len7 == wsd_pkg::LEN7_EXT64);
  assign acc_shift = {acc_q[LenW-9:0], b};
  // Any bit pushed out of the top means the length is above the limit
  assign ovf_shift = ovf_q | (|acc_q[LenW-1 -: 8]);
  assign cnt_dec   = cnt_q - 4'd1;
  assign cnt_zero  = (cnt_dec == 4'd0);
  assign rem_dec   = rem_q - LenW'(1);
  assign data_last = (rem_dec == '0);
  assign key_byte  = 8'(key_q >> {~idx_q, 3'b000});

  assign hdr_at_hdr1 = (phase_q == wsd_pkg::PH_HDR1) && !len_ext && !b[7];
  assign ext_fin     = (phase_q == wsd_pkg::PH_EXT) && cnt_zero;
  assign ext_bad     = ext_fin && ovf_shift;
  assign ext_key     = ext_fin && !ovf_shift && hb_q[8];
  assign key_fin     = (phase_q == wsd_pkg::PH_KEY) && cnt_zero;
  assign hdr_done    = hdr_at_hdr1 || (ext_fin && !ovf_shift && !hb_q[8]) || key_fin;

  // Hold the length unless a beat is taken
  assign acc_n = !accept_i                     ? acc_q :
                 (phase_q == wsd_pkg::PH_HDR1) ? (len_ext ? '0 : LenW'(len7)) :
                 (phase_q == wsd_pkg::PH_EXT)  ? acc_shift : acc_q;
  assign len_zero = (acc_n == '0);

  // The buffer end always returns the parser to its reset state
  assign go_idle = accept_i && endb;

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (go_idle) begin
      phase_d = wsd_pkg::PH_HDR0;
    end else if (accept_i) begin
      unique case (phase_q)
        wsd_pkg::PH_HDR1: begin
          if (hdr_done) begin
            phase_d = len_zero ? wsd_pkg::PH_DRAIN : wsd_pkg::PH_DATA;
          end else begin
            phase_d = len_ext ? wsd_pkg::PH_EXT : wsd_pkg::PH_KEY;
          end
        end
        wsd_pkg::PH_EXT: begin
          if (ext_bad) begin
            phase_d = wsd_pkg::PH_DRAIN;
          end else if (hdr_done) begin
            phase_d = len_zero ? wsd_pkg::PH_DRAIN : wsd_pkg::PH_DATA;
          end else if (ext_key) begin
            phase_d = wsd_pkg::PH_KEY;
          end
        end
        wsd_pkg::PH_KEY: begin
          if (hdr_done) begin
            phase_d = len_zero ? wsd_pkg::PH_DRAIN : wsd_pkg::PH_DATA;
          end
        end
        wsd_pkg::PH_DATA: begin
          if (data_last) begin
            phase_d = wsd_pkg::PH_DRAIN;
          end
        end
        wsd_pkg::PH_DRAIN: phase_d = wsd_pkg::PH_DRAIN;
        default:           phase_d = wsd_pkg::PH_HDR1;
      endcase
    end
  end

  // Field updates and results
  always_comb begin
    cnt_n  = cnt_q;
    ovf_n  = ovf_q;
    rem_n  = rem_q;
    key_n  = key_q;
    idx_n  = idx_q;
    hb_n   = hb_q;
    disc_n = disc_q;
    push_o = '0;
    if (accept_i) begin
      unique case (phase_q)
        wsd_pkg::PH_HDR1: begin
          hb_n  = {b[7], hb_q[7:0]};
          key_n = '0;
          ovf_n = 1'b0;
          if (len7 == wsd_pkg::LEN7_EXT16) begin
            cnt_n = wsd_pkg::EXT16_BYTES;
          end else if (len7 == wsd_pkg::LEN7_EXT64) begin
            cnt_n = wsd_pkg::EXT64_BYTES;
          end else if (b[7]) begin
            cnt_n = wsd_pkg::KEY_BYTES;
          end
        end
        wsd_pkg::PH_EXT: begin
          ovf_n = ovf_shift;
          cnt_n = ext_key ? wsd_pkg::KEY_BYTES : cnt_dec;
        end
        wsd_pkg::PH_KEY: begin
          key_n = {key_q[23:0], b};
          cnt_n = cnt_dec;
        end
        wsd_pkg::PH_DATA: begin
          idx_n = idx_q + 2'd1;
          rem_n = rem_dec;
          push_o.res0.valid = 1'b1;
          push_o.res0.res   = mk_res(wsd_pkg::KIND_PAYLOAD, hb_q, acc_q, b ^ key_byte,
                                     data_last);
          if (data_last) begin
            disc_n = 1'b1;
          end else if (endb) begin
            push_o.res1.valid = 1'b1;
            push_o.res1.res   = mk_err();
          end
        end
        wsd_pkg::PH_DRAIN: begin
          if (endb && disc_q) begin
            push_o.res0.valid = 1'b1;
            push_o.res0.res   = mk_err();
          end
        end
        default: begin
          hb_n = {1'b0, b};
          if (endb) begin
            push_o.res0.valid = 1'b1;
            push_o.res0.res   = mk_err();
          end
        end
      endcase

      // Header stages: header result, length error, or short-buffer error
      if (hdr_done) begin
        rem_n  = acc_n;
        idx_n  = 2'd0;
        disc_n = len_zero;
        push_o.res0.valid = 1'b1;
        push_o.res0.res   = mk_res(wsd_pkg::KIND_HEADER, hb_n, acc_n, 8'd0, len_zero);
        if (endb && !len_zero) begin
          push_o.res1.valid = 1'b1;
          push_o.res1.res   = mk_err();
        end
      end else if (ext_bad) begin
        disc_n = 1'b0;
        push_o.res0.valid = 1'b1;
        push_o.res0.res   = mk_err();
      end else if (endb && ((phase_q == wsd_pkg::PH_HDR1) || (phase_q == wsd_pkg::PH_EXT) ||
                            (phase_q == wsd_pkg::PH_KEY))) begin
        push_o.res0.valid = 1'b1;
        push_o.res0.res   = mk_err();
      end
    end

    cnt_d  = go_idle ? '0 : cnt_n;
    acc_d  = go_idle ? '0 : acc_n;
    ovf_d  = go_idle ? 1'b0 : ovf_n;
    rem_d  = go_idle ? '0 : rem_n;
    key_d  = go_idle ? '0 : key_n;
    idx_d  = go_idle ? '0 : idx_n;
    hb_d   = go_idle ? '0 : hb_n;
    disc_d = go_idle ? 1'b0 : disc_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= wsd_pkg::PH_HDR0;
      cnt_q   <= '0;
      acc_q   <= '0;
      ovf_q   <= 1'b0;
      rem_q   <= '0;
      key_q   <= '0;
      idx_q   <= '0;
      hb_q    <= '0;
      disc_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      acc_q   <= acc_d;
      ovf_q   <= ovf_d;
      rem_q   <= rem_d;
      key_q   <= key_d;
      idx_q   <= idx_d;
      hb_q    <= hb_d;
      disc_q  <= disc_d;
    end
  end

  a_tail_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.res1.valid |-> push_o.res0.valid)
    else $error("second result pushed without a first");

  a_tail_is_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.res1.valid |-> (push_o.res1.res.kind == wsd_pkg::KIND_ERROR) &&
                          push_o.res1.res.frame_last)
    else $error("second result of a beat is not a closing error");

  a_end_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && beat_i.buffer_end) |=>
      (phase_q == wsd_pkg::PH_HDR0) && (acc_q == '0) && !disc_q && (hb_q == '0))
    else $error("buffer end did not return the parser to idle");

  a_push_needs_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept_i |-> !push_o.res0.valid)
    else $error("result pushed without an accepted beat");

endmodule

@@ design/wsd_result_fifo.sv @@
module wsd_result_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wsd_pkg::wsd_push_t push_i,
  output logic               room_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output wsd_pkg::wsd_out_t  out_data_o
);

  localparam int unsigned PtrW = $clog2(wsd_pkg::RES_DEPTH);
  localparam int unsigned CntW = PtrW + 1;

  wsd_pkg::wsd_out_t mem_q [wsd_pkg::RES_DEPTH];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_q];
  assign pop         = out_valid_o && out_ready_i;
  // Take a beat only when both of its possible results fit
  assign room_o      = (cnt_q <= CntW'(wsd_pkg::RES_DEPTH - 2));

  assign wr_d  = wr_q + PtrW'(push_i.res0.valid) + PtrW'(push_i.res1.valid);
  assign rd_d  = rd_q + PtrW'(pop);
  assign cnt_d = cnt_q + CntW'(push_i.res0.valid) + CntW'(push_i.res1.valid) - CntW'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.res0.valid) begin
      mem_q[wr_q] <= push_i.res0.res;
    end
    if (push_i.res1.valid) begin
      mem_q[wr_q + PtrW'(1)] <= push_i.res1.res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.res1.valid |-> (cnt_q <= CntW'(wsd_pkg::RES_DEPTH - 2)))
    else $error("result queue overflow");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(wsd_pkg::RES_DEPTH))
    else $error("result queue count out of range");

endmodule

@@ design/websocket_frame_deframer.sv @@
// Channel   Dir  Payload                                     Handshake
// in_i      in   data_byte[7:0], buffer_end                  valid/ready
// out_o     out  kind, fin, rsv1-3, opcode, masked,          valid/ready
//                payload_length[62:0], out_byte, frame_last
//
// One byte is taken every cycle while the result queue has two free slots; a
// beat's results are registered in the queue and reach out_o in order.
// A beat yields zero, one or two results (header or payload, then an error when
// the buffer ends inside the frame); the four-entry result queue absorbs these.
// Reset (rst_ni low) clears the parser to wait for a first header byte and empties
// the queue. A stall on out_o fills the queue; in_i.ready drops once fewer than
// two slots are free and rises again as results are taken.
module websocket_frame_deframer #(
  parameter int unsigned LENGTH_BITS = wsd_pkg::LENGTH_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  wsd_stream_if.sink   in_i,
  wsd_stream_if.source out_o
);

  wsd_pkg::wsd_push_t push;
  wsd_pkg::wsd_in_t   beat;
  wsd_pkg::wsd_out_t  res;
  logic               room;
  logic               accept;

  // Accept a beat whenever the queue can hold everything it may produce
  assign in_i.ready = room;
  assign accept     = in_i.valid && room;
  assign beat       = in_i.data;

  // Header decode, extended length and key collection, unmasking, error checks
  wsd_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .beat_i   (beat),
    .push_o   (push)
  );

  // Hold results until the sink takes them
  wsd_result_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (res)
  );

  assign out_o.data = res;

  a_push_only_on_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.res0.valid |-> room)
    else $error("results pushed while the queue had no room");

endmodule

@@ test/tb_websocket_frame_deframer.sv @@
module tb_websocket_frame_deframer;
  timeunit 1ns;
  timeprecision 1ps;

  // How the payload length is encoded in the second header byte
  typedef enum int unsigned {
    LEN_SHORT,
    LEN_EXT16,
    LEN_EXT64
  } len_code_e;

  // Largest payload length the block takes without flagging an oversize frame
  localparam logic [63:0] LEN_LIMIT = (wsd_pkg::LENGTH_BITS_DEF >= 63) ?
                                      64'h7FFF_FFFF_FFFF_FFFF :
                                      ((64'd1 << wsd_pkg::LENGTH_BITS_DEF) - 64'd1);

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  wsd_stream_if #(.T(wsd_pkg::wsd_in_t))  in_if ();
  wsd_stream_if #(.T(wsd_pkg::wsd_out_t)) out_if ();

  websocket_frame_deframer DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #1 clk_i = ~clk_i;

  // Results owed by the block, oldest first
  wsd_pkg::wsd_out_t expected_results[$];
  int unsigned fail_count    = 0;
  // Beats that the parser acts on; bytes dropped while draining are not counted
  int unsigned counted_beats = 0;

  // Idle controls for the sender and the receiver
  bit          src_gaps_on       = 1'b0;
  bit          sink_gaps_on      = 1'b0;
  int unsigned sink_hold_cycles  = 0;

  // Shadow copy of the parser state
  wsd_pkg::phase_e ph;
  logic [3:0]  fld_cnt;
  logic [63:0] len_acc;
  logic [62:0] remaining;
  logic [31:0] key;
  logic [1:0]  key_idx;
  logic [8:0]  hdr;
  logic        owe_error;

  // ------------------------------------------------------------------
  // Frame parser prediction
  // ------------------------------------------------------------------

  // Return the parser to waiting for a first header byte
  function automatic void parser_idle();
    ph        = wsd_pkg::PH_HDR0;
    fld_cnt   = '0;
    len_acc   = '0;
    remaining = '0;
    key       = '0;
    key_idx   = '0;
    hdr       = '0;
    owe_error = 1'b0;
  endfunction

  // Queue one expected result; error results carry only kind and frame_last
  function automatic void owe_result(wsd_pkg::kind_e k, logic [7:0] b, logic last);
    wsd_pkg::wsd_out_t r;
    r            = '0;
    r.kind       = k;
    r.frame_last = last;
    if (k != wsd_pkg::KIND_ERROR) begin
      r.fin            = hdr[7];
      r.rsv1           = hdr[6];
      r.rsv2           = hdr[5];
      r.rsv3           = hdr[4];
      r.opcode         = hdr[3:0];
      r.masked         = hdr[8];
      r.payload_length = len_acc[62:0];
      r.out_byte       = b;
    end
    expected_results.push_back(r);
  endfunction

  function automatic void owe_error_and_idle();
    owe_result(wsd_pkg::KIND_ERROR, 8'h00, 1'b1);
    parser_idle();
  endfunction

  // Header complete: empty frames end here, others move on to the payload
  function automatic void finish_header(logic e);
    if (len_acc == '0) begin
      owe_result(wsd_pkg::KIND_HEADER, 8'h00, 1'b1);
      if (e) begin
        parser_idle();
      end else begin
        ph        = wsd_pkg::PH_DRAIN;
        owe_error = 1'b1;
      end
    end else begin
      owe_result(wsd_pkg::KIND_HEADER, 8'h00, 1'b0);
      remaining = len_acc[62:0];
      key_idx   = '0;
      ph        = wsd_pkg::PH_DATA;
      if (e) owe_error_and_idle();
    end
  endfunction

  // Advance the shadow parser by one accepted beat
  function automatic void deframe_byte(logic [7:0] b, logic e);
    logic [7:0] key_byte;
    logic       last;
    if (ph != wsd_pkg::PH_DRAIN) counted_beats++;
    case (ph)
      wsd_pkg::PH_HDR1: begin
        hdr     = {b[7], hdr[7:0]};
        key     = '0;
        len_acc = '0;
        if (b[6:0] == wsd_pkg::LEN7_EXT16) begin
          fld_cnt = wsd_pkg::EXT16_BYTES;
          ph      = wsd_pkg::PH_EXT;
        end else if (b[6:0] == wsd_pkg::LEN7_EXT64) begin
          fld_cnt = wsd_pkg::EXT64_BYTES;
          ph      = wsd_pkg::PH_EXT;
        end else begin
          len_acc = {57'd0, b[6:0]};
          if (b[7]) begin
            fld_cnt = wsd_pkg::KEY_BYTES;
            ph      = wsd_pkg::PH_KEY;
          end else begin
            finish_header(e);
            return;
          end
        end
        if (e) owe_error_and_idle();
      end
      wsd_pkg::PH_EXT: begin
        len_acc = {len_acc[55:0], b};
        fld_cnt = fld_cnt - 4'd1;
        if (fld_cnt == '0) begin
          if (len_acc > LEN_LIMIT) begin
            // Oversize: flag at once, then drop silently up to the buffer end
            owe_result(wsd_pkg::KIND_ERROR, 8'h00, 1'b1);
            if (e) begin
              parser_idle();
            end else begin
              ph        = wsd_pkg::PH_DRAIN;
              owe_error = 1'b0;
            end
            return;
          end
          if (hdr[8]) begin
            fld_cnt = wsd_pkg::KEY_BYTES;
            ph      = wsd_pkg::PH_KEY;
          end else begin
            finish_header(e);
            return;
          end
        end
        if (e) owe_error_and_idle();
      end
      wsd_pkg::PH_KEY: begin
        key     = {key[23:0], b};
        fld_cnt = fld_cnt - 4'd1;
        if (fld_cnt == '0) begin
          finish_header(e);
          return;
        end
        if (e) owe_error_and_idle();
      end
      wsd_pkg::PH_DATA: begin
        key_byte  = key[8 * (3 - key_idx) +: 8];
        key_idx   = key_idx + 2'd1;
        remaining = remaining - 63'd1;
        last      = (remaining == '0);
        owe_result(wsd_pkg::KIND_PAYLOAD, b ^ key_byte, last);
        if (last) begin
          if (e) begin
            parser_idle();
          end else begin
            ph        = wsd_pkg::PH_DRAIN;
            owe_error = 1'b1;
          end
        end else if (e) begin
          owe_error_and_idle();
        end
      end
      wsd_pkg::PH_DRAIN: begin
        if (e) begin
          if (owe_error) owe_error_and_idle();
          else parser_idle();
        end
      end
      default: begin
        parser_idle();
        hdr = {1'b0, b};
        if (e) owe_error_and_idle();
        else ph = wsd_pkg::PH_HDR1;
      end
    endcase
  endfunction

  // ------------------------------------------------------------------
  // Sender side
  // ------------------------------------------------------------------

  // Idle stretch: mostly none or short, now and then long
  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 90) return $urandom_range(1, 3);
    else return $urandom_range(8, 40);
  endfunction

  // Offer one beat, hold it until taken, then predict its results.
  // Valid stays high into the next call unless a gap is drawn.
  task automatic send_beat(input logic [7:0] b, input logic e);
    wsd_pkg::wsd_in_t beat;
    int unsigned      gap;
    beat.data_byte  = b;
    beat.buffer_end = e;
    in_if.valid <= 1'b1;
    in_if.data  <= beat;
    do @(posedge clk_i); while (!in_if.ready);
    deframe_byte(b, e);
    gap = src_gaps_on ? idle_length() : 0;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Build one receive buffer around a frame and send it, flagging its last byte.
  // header_cut keeps only that many header bytes; otherwise payload_cnt payload
  // bytes and extra_cnt trailing bytes follow the header.
  task automatic send_frame(input logic [7:0] first, input logic masked,
                            input logic [63:0] len, input len_code_e code,
                            input int unsigned payload_cnt, input int unsigned extra_cnt,
                            input int unsigned header_cut);
    logic [7:0]  bytes[$];
    logic [31:0] mkey;
    mkey = $urandom;
    bytes.push_back(first);
    case (code)
      LEN_EXT16: begin
        bytes.push_back({masked, wsd_pkg::LEN7_EXT16});
        bytes.push_back(len[15:8]);
        bytes.push_back(len[7:0]);
      end
      LEN_EXT64: begin
        bytes.push_back({masked, wsd_pkg::LEN7_EXT64});
        for (int i = 7; i >= 0; i--) bytes.push_back(len[8 * i +: 8]);
      end
      default: bytes.push_back({masked, len[6:0]});
    endcase
    if (masked) for (int i = 3; i >= 0; i--) bytes.push_back(mkey[8 * i +: 8]);
    if (header_cut != 0) begin
      bytes = bytes[0:header_cut - 1];
    end else begin
      repeat (payload_cnt + extra_cnt) bytes.push_back(8'($urandom));
    end
    foreach (bytes[i]) send_beat(bytes[i], i == bytes.size() - 1);
  endtask

  // ------------------------------------------------------------------
  // Receiver side: random stalls, plus a long hold-off on request
  // ------------------------------------------------------------------
  initial begin : result_taker
    int unsigned gap;
    out_if.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      if (sink_hold_cycles != 0) begin
        // Hold off long enough for the result queue to fill and stall the input
        out_if.ready <= 1'b0;
        repeat (sink_hold_cycles) @(posedge clk_i);
        sink_hold_cycles = 0;
      end else begin
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        gap = sink_gaps_on ? idle_length() : 0;
        if (gap != 0) begin
          out_if.ready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Result checking
  // ------------------------------------------------------------------
  function automatic string describe_result(wsd_pkg::wsd_out_t r);
    return $sformatf("kind=%0d fin=%b rsv=%b%b%b op=%h masked=%b len=%0h byte=%h last=%b",
                     r.kind, r.fin, r.rsv1, r.rsv2, r.rsv3, r.opcode, r.masked,
                     r.payload_length, r.out_byte, r.frame_last);
  endfunction

  // Compare each result beat with the oldest owed result
  always @(posedge clk_i) begin : result_checker
    wsd_pkg::wsd_out_t got;
    wsd_pkg::wsd_out_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("[%0t] unexpected result: %s", $realtime, describe_result(got));
      end else begin
        want = expected_results.pop_front();
        if (got.kind !== want.kind || got.fin !== want.fin || got.rsv1 !== want.rsv1 ||
            got.rsv2 !== want.rsv2 || got.rsv3 !== want.rsv3 ||
            got.opcode !== want.opcode || got.masked !== want.masked ||
            got.payload_length !== want.payload_length ||
            got.out_byte !== want.out_byte || got.frame_last !== want.frame_last) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("[%0t] result mismatch", $realtime);
            $display("  expected %s", describe_result(want));
            $display("  actual   %s", describe_result(got));
          end
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------

  // Header cuts, length encodings at their extremes, trailing bytes, oversize
  task automatic test_directed_frames();
    src_gaps_on  = 1'b0;
    sink_gaps_on = 1'b0;
    // Buffer ends inside the header: on the first byte, a length byte, the key
    send_frame(8'h81, 1'b0, 64'd0, LEN_SHORT, 0, 0, 1);
    send_frame(8'h82, 1'b1, 64'd300, LEN_EXT16, 0, 0, 2);
    send_frame(8'h02, 1'b0, 64'h1234, LEN_EXT64, 0, 0, 5);
    send_frame(8'h89, 1'b1, 64'd3, LEN_SHORT, 0, 0, 4);
    // Empty frames: unmasked, masked, and followed by extra bytes
    send_frame(8'h89, 1'b0, 64'd0, LEN_SHORT, 0, 0, 0);
    send_frame(8'h8A, 1'b1, 64'd0, LEN_SHORT, 0, 0, 0);
    send_frame(8'h88, 1'b0, 64'd0, LEN_SHORT, 0, 2, 0);
    // Exact fits: header bits all set and all clear, non-minimal encodings
    send_frame(8'hFF, 1'b1, 64'd125, LEN_SHORT, 125, 0, 0);
    send_frame(8'h00, 1'b0, 64'd5, LEN_SHORT, 5, 0, 0);
    send_frame(8'h70, 1'b1, 64'd0, LEN_EXT16, 0, 0, 0);
    send_frame(8'h81, 1'b1, 64'd3, LEN_EXT64, 3, 0, 0);
    // Buffer ends inside the payload, down to right after the header
    send_frame(8'h82, 1'b1, 64'hFFFF, LEN_EXT16, 3, 0, 0);
    send_frame(8'h82, 1'b0, LEN_LIMIT, LEN_EXT64, 2, 0, 0);
    send_frame(8'h82, 1'b0, 64'd4, LEN_SHORT, 0, 0, 0);
    send_frame(8'h01, 1'b1, 64'd9, LEN_SHORT, 4, 0, 0);
    // Frame ends before the buffer
    send_frame(8'h81, 1'b1, 64'd6, LEN_SHORT, 6, 3, 0);
    // Oversize length: dropped bytes after it, and buffer end on the length
    send_frame(8'h81, 1'b1, 64'h8000_0000_0000_0000, LEN_EXT64, 0, 3, 0);
    send_frame(8'h81, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, LEN_EXT64, 0, 0, 0);
  endtask

  // Stall the output for a long stretch while the sender keeps offering
  task automatic test_output_backpressure();
    src_gaps_on      = 1'b0;
    sink_gaps_on     = 1'b0;
    sink_hold_cycles = 120;
    send_frame(8'h82, 1'b1, 64'd40, LEN_SHORT, 40, 0, 0);
    send_frame(8'h81, 1'b0, 64'd20, LEN_SHORT, 20, 2, 0);
  endtask

  // Mostly well-formed frames with random content; the rest cut, padded,
  // oversized or plain noise
  task automatic test_random_frames(input int unsigned beat_goal);
    logic [7:0]  first;
    logic        masked;
    logic [63:0] len;
    len_code_e   code;
    int unsigned pick;
    int unsigned shape;
    int unsigned most;
    int unsigned hdr_size;
    int unsigned n;
    int unsigned stop_at;
    stop_at = counted_beats + beat_goal;
    while (counted_beats < stop_at) begin
      // Rotate idle modes so some stretches run with no gaps at all
      case ((counted_beats / 250) % 4)
        0: begin src_gaps_on = 1'b0; sink_gaps_on = 1'b0; end
        1: begin src_gaps_on = 1'b1; sink_gaps_on = 1'b0; end
        2: begin src_gaps_on = 1'b0; sink_gaps_on = 1'b1; end
        default: begin src_gaps_on = 1'b1; sink_gaps_on = 1'b1; end
      endcase
      first  = 8'($urandom);
      masked = 1'($urandom_range(0, 1));
      pick   = $urandom_range(0, 99);
      if (pick < 70) begin
        code = LEN_SHORT;
        len  = 64'($urandom_range(0, 20));
      end else if (pick < 78) begin
        code = LEN_SHORT;
        len  = 64'($urandom_range(100, 125));
      end else if (pick < 88) begin
        code = LEN_EXT16;
        len  = (pick < 86) ? 64'($urandom_range(0, 40)) : 64'($urandom_range(126, 260));
      end else begin
        code = LEN_EXT64;
        len  = 64'($urandom_range(0, 30));
      end
      shape = $urandom_range(0, 99);
      if (shape < 72) begin
        send_frame(first, masked, len, code, 32'(len), 0, 0);
      end else if (shape < 80) begin
        send_frame(first, masked, len, code, 32'(len), $urandom_range(1, 4), 0);
      end else if (shape < 88) begin
        // Buffer ends inside the payload; widen the length field now and then
        pick = $urandom_range(0, 2);
        if (pick == 0) begin
          code = LEN_EXT64;
          len  = {1'b0, 31'($urandom), 32'($urandom)};
        end else if (pick == 1) begin
          code = LEN_EXT16;
          len  = {48'd0, 16'($urandom)};
        end
        if (len == '0) len = 64'd1;
        most = (len > 64'd7) ? 32'd6 : 32'(len) - 32'd1;
        send_frame(first, masked, len, code, $urandom_range(0, most), 0, 0);
      end else if (shape < 93) begin
        hdr_size = 2 + (masked ? 4 : 0) +
                   ((code == LEN_EXT16) ? 2 : (code == LEN_EXT64) ? 8 : 0);
        send_frame(first, masked, len, code, 0, 0, $urandom_range(1, hdr_size - 1));
      end else if (shape < 97) begin
        len = {1'b1, 31'($urandom), 32'($urandom)};
        send_frame(first, masked, len, LEN_EXT64, 0, $urandom_range(0, 3), 0);
      end else begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) send_beat(8'($urandom), i == n - 1);
      end
    end
  endtask

  // ------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------
  initial begin : run_tests
    int unsigned waited;
    in_if.valid <= 1'b0;
    in_if.data  <= '0;
    parser_idle();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_frames();
    test_output_backpressure();
    test_random_frames(1200);
    in_if.valid <= 1'b0;

    // Let owed results arrive, then keep the clock running to catch strays
    waited = 0;
    while (expected_results.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (10) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      fail_count += expected_results.size();
      $display("%0d results never arrived, oldest: %s", expected_results.size(),
               describe_result(expected_results[0]));
    end

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin : run_limit
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ websocket_frame_deframer.f @@
design/wsd_pkg.sv
design/wsd_stream_if.sv
design/wsd_parser.sv
design/wsd_result_fifo.sv
design/websocket_frame_deframer.sv
test/tb_websocket_frame_deframer.sv
